// File: rtl/core/tmq_pkg.sv
// Package for the typed message queue descriptor store.
// Sizes, opcodes, status codes and helper types. No dependencies.
package tmq_pkg;

    localparam int NUM_QUEUES      = 8;
    localparam int SLOTS_PER_QUEUE = 16;
    localparam int MAX_MSG_BYTES   = 8192;
    localparam int TOTAL_SLOTS     = NUM_QUEUES * SLOTS_PER_QUEUE;
    localparam int QW = 3;
    localparam int SW = 4;
    localparam int AW = QW + SW;

    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_RECV  = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_COUNT = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NO_ROOM = 3'd2;
    localparam logic [2:0] ST_NO_MSG  = 3'd3;
    localparam logic [2:0] ST_TOO_BIG = 3'd4;

    localparam logic [0:0] CFG_MASK = 1'd0;
    localparam logic [0:0] CFG_CAP  = 1'd1;

    // descriptor held in the slot memory
    typedef struct packed {
        logic [31:0] typ;
        logic [13:0] size;
        logic [31:0] order;
        logic [15:0] handle;
    } t_entry;

endpackage

// File: rtl/core/typed_message_queue_select.sv
// Top level of the typed message queue descriptor store.
// Uses tmq_pkg; holds the slot memory, the per-queue counters and the sequencer.
//
// One request at a time. Send and receive read the queue's sixteen slots from
// the descriptor memory one per cycle through a registered read port, and a
// send then writes back one slot. Flush, count and an invalid request skip the
// scan and go straight to the done state. The scan over the slot memory's
// single read port sets the rate. The result sits in an output register and is
// held until taken; a new request may be accepted meanwhile, but it does not
// finish while the previous result waits. Valid bits live in flip-flops (128)
// cleared by reset; no clearing pass.
module typed_message_queue_select
    import tmq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [2:0]         i_queue_id,
    input  logic signed [31:0] i_msg_type,
    input  logic [13:0]        i_msg_size,
    input  logic [15:0]        i_payload_handle,
    input  logic               i_truncate_ok,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_recv_type,
    output logic [13:0]        o_out_size,
    output logic [15:0]        o_out_handle,
    output logic [4:0]         o_message_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [7:0]  r_mask;
    logic [17:0] r_cap;
    logic [TOTAL_SLOTS-1:0] r_valid;
    logic [17:0] r_qbytes [NUM_QUEUES];
    logic [31:0] r_norder [NUM_QUEUES];
    t_entry      r_mem [TOTAL_SLOTS];
    t_entry      r_rd;

    // latched request
    logic [1:0]         r_op;
    logic [QW-1:0]      r_q;
    logic signed [31:0] r_typ;
    logic [13:0]        r_size;
    logic [15:0]        r_handle;
    logic               r_trunc;
    logic [2:0]         r_status;

    // scan
    logic [SW:0]   r_idx;      // read address counter
    logic          r_rdv;      // read data valid this cycle
    logic [SW-1:0] r_ridx;     // slot of read data
    logic          r_found;
    logic [SW-1:0] r_best;
    logic signed [31:0] r_best_t;
    logic [31:0]   r_best_age;
    logic [13:0]   r_best_size;
    logic [15:0]   r_best_handle;
    logic          r_free_ok;
    logic [SW-1:0] r_free;

    // output
    logic        r_ovalid;
    logic [2:0]  r_ostatus;
    logic [31:0] r_otype;
    logic [13:0] r_osize;
    logic [15:0] r_ohandle;
    logic [4:0]  r_ocount;

    logic [AW-1:0] n_raddr;
    logic          rd_valid_bit;
    logic signed [31:0] t_cur;
    logic [31:0]   age_cur;
    logic          match, better;
    logic signed [32:0] neg_sel;
    logic [SLOTS_PER_QUEUE-1:0] qvalid;
    logic [4:0]    cnt;
    logic [18:0]   sum_bytes;
    logic [13:0]   dsize;
    logic          done_go;
    logic          send_ok;
    logic          recv_ok;
    logic [2:0]    n_status;
    logic [31:0]   n_otype;
    logic [13:0]   n_osize;
    logic [15:0]   n_ohandle;
    logic [4:0]    n_ocount;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_recv_type = r_otype;
    assign o_out_size  = r_osize;
    assign o_out_handle = r_ohandle;
    assign o_message_count = r_ocount;

    assign n_raddr = {r_q, r_idx[SW-1:0]};
    assign qvalid  = r_valid[r_q*SLOTS_PER_QUEUE +: SLOTS_PER_QUEUE];

    // finish only when the result register is free or being emptied
    assign done_go = (r_state == S_DONE) && (!r_ovalid || i_ready);

    // descriptor memory: one read, one write port
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_raddr];
        if (done_go && r_op == OP_SEND && send_ok && r_status == ST_OK) begin
            r_mem[{r_q, r_free}] <= '{typ: r_typ, size: r_size,
                                     order: r_norder[r_q], handle: r_handle};
        end
    end

    // match and ordering of the slot just read
    always_comb begin
        rd_valid_bit = r_valid[{r_q, r_ridx}];
        t_cur   = r_rd.typ;
        age_cur = r_norder[r_q] - r_rd.order;
        neg_sel = -{r_typ[31], r_typ};
        if (r_typ == 0)     match = 1'b1;
        else if (r_typ > 0) match = (t_cur == r_typ);
        else                match = ({t_cur[31], t_cur} <= neg_sel);
        if (!r_found)                           better = 1'b1;
        else if (r_typ < 0 && t_cur != r_best_t) better = (t_cur < r_best_t);
        else                                    better = (age_cur > r_best_age);
        cnt = '0;
        for (int i = 0; i < SLOTS_PER_QUEUE; i++) cnt = cnt + 5'(qvalid[i]);
        sum_bytes = {1'b0, r_qbytes[r_q]} + 19'(r_size);
        dsize = (r_best_size > r_size) ? r_size : r_best_size;
        send_ok = r_free_ok && (sum_bytes <= {1'b0, r_cap});
        recv_ok = r_found && !(r_best_size > r_size && !r_trunc);
    end

    // result of the finishing request
    always_comb begin
        n_status  = r_status;
        n_otype   = '0;
        n_osize   = '0;
        n_ohandle = '0;
        n_ocount  = '0;
        if (r_status == ST_OK) begin
            case (r_op)
                OP_SEND: begin
                    if (!send_ok) n_status = ST_NO_ROOM;
                    else          n_osize  = r_size;
                end
                OP_RECV: begin
                    if (!r_found) begin
                        n_status = ST_NO_MSG;
                    end else if (!recv_ok) begin
                        n_status = ST_TOO_BIG;
                    end else begin
                        n_otype   = r_best_t;
                        n_osize   = dsize;
                        n_ohandle = r_best_handle;
                    end
                end
                OP_FLUSH: n_ocount = '0;
                default:  n_ocount = cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mask   <= 8'hFF;
            r_cap    <= 18'd131072;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_rdv    <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_qbytes[i] <= '0;
                r_norder[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MASK) r_mask <= i_cfg_data[7:0];
                else                         r_cap  <= i_cfg_data;
            end
            // result register: loaded on completion, emptied once taken
            if (done_go)      r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_op <= i_opcode; r_q <= i_queue_id; r_typ <= i_msg_type;
                        r_size <= i_msg_size; r_handle <= i_payload_handle;
                        r_trunc <= i_truncate_ok;
                        r_idx <= '0; r_rdv <= 1'b0; r_found <= 1'b0;
                        r_free_ok <= 1'b0;
                        if (!r_mask[i_queue_id]) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_DONE;
                        end else if (i_opcode == OP_SEND && (i_msg_type < 1 ||
                                     i_msg_size > 14'(MAX_MSG_BYTES))) begin
                            r_status <= ST_INVALID;
                            r_state  <= S_DONE;
                        end else if (i_opcode == OP_SEND || i_opcode == OP_RECV) begin
                            r_status <= ST_OK;
                            r_state  <= S_SCAN;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    // issue reads, evaluate the previous one
                    r_rdv  <= !r_idx[SW];
                    r_ridx <= r_idx[SW-1:0];
                    if (!r_idx[SW]) r_idx <= r_idx + 1'b1;
                    if (r_rdv) begin
                        if (!rd_valid_bit && !r_free_ok) begin
                            r_free_ok <= 1'b1; r_free <= r_ridx;
                        end
                        if (rd_valid_bit && match && better) begin
                            r_found <= 1'b1; r_best <= r_ridx; r_best_t <= t_cur;
                            r_best_age <= age_cur; r_best_size <= r_rd.size;
                            r_best_handle <= r_rd.handle;
                        end
                    end
                    if (r_rdv && r_idx[SW]) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (done_go) begin
                        r_state   <= S_IDLE;
                        r_ostatus <= n_status;
                        r_otype   <= n_otype;
                        r_osize   <= n_osize;
                        r_ohandle <= n_ohandle;
                        r_ocount  <= n_ocount;
                        if (r_status == ST_OK) begin
                            case (r_op)
                                OP_SEND: begin
                                    if (send_ok) begin
                                        r_valid[{r_q, r_free}] <= 1'b1;
                                        r_norder[r_q] <= r_norder[r_q] + 32'd1;
                                        r_qbytes[r_q] <= sum_bytes[17:0];
                                    end
                                end
                                OP_RECV: begin
                                    if (recv_ok) begin
                                        r_valid[{r_q, r_best}] <= 1'b0;
                                        if (r_qbytes[r_q] >= 18'(r_best_size))
                                            r_qbytes[r_q] <= r_qbytes[r_q]
                                                             - 18'(r_best_size);
                                        else
                                            r_qbytes[r_q] <= '0;
                                    end
                                end
                                OP_FLUSH: begin
                                    r_valid[r_q*SLOTS_PER_QUEUE +: SLOTS_PER_QUEUE] <= '0;
                                    r_qbytes[r_q] <= '0;
                                    r_norder[r_q] <= '0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
